@@ rtl/core/bnw_pkg.sv @@
// shared types and codes for the backoff n-gram walk block
// used by bnw_front, bnw_back and backoff_ngram_walk
package bnw_pkg;
   typedef enum logic [1:0] {
      CMD_NODE_WR = 2'd0,
      CMD_ARC_WR  = 2'd1,
      CMD_WALK    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_START_FIN = 2'd1,
      ST_REACH_FIN = 2'd2,
      ST_HOP_LIMIT = 2'd3
   } status_type;

   localparam int unsigned CSR_FINAL_NODE = 0;
   localparam int unsigned CSR_MAX_HOPS   = 1;

   // command travels in tuser, the other request fields in tdata
   localparam int unsigned REQ_USER_BITS = 2;
   localparam int unsigned REQ_BITS = 18 + 16 + 16 + 20 + 19 + 16 + 16;
   localparam int unsigned REQ_BYTES_BITS = ((REQ_BITS + 7) / 8) * 8;
   // status and saturation flag travel in tuser
   localparam int unsigned RSP_USER_BITS = 2 + 1;
   localparam int unsigned RSP_BITS = 16 + 20 + 4;
   localparam int unsigned RSP_BYTES_BITS = ((RSP_BITS + 7) / 8) * 8;

   // one classified item as held in the queue between front and back
   typedef struct packed {
      cmd_type     cmd;
      logic [17:0] index;
      logic [15:0] symbol;
      logic [15:0] target;
      logic [19:0] score;
      logic [18:0] limit;
      logic [15:0] node;
      logic [15:0] walk_sym;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] next_node;
      logic [19:0] score;
      logic [3:0]  hops;
      logic        sat;
   } result_type;
endpackage

@@ rtl/core/bnw_front.sv @@
// front part: takes request transactions, unpacks them into a two-entry queue
// depends on bnw_pkg
module bnw_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bnw_pkg::REQ_USER_BITS-1:0]     req_tuser,
   input  logic [bnw_pkg::REQ_BYTES_BITS-1:0]    req_tdata,
   output logic                                  q_valid,
   input  logic                                  q_take,
   output bnw_pkg::item_type                     q_item
);
   import bnw_pkg::*;

   item_type   slot_ff [2];
   item_type   unpacked;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      unpacked.cmd      = cmd_type'(req_tuser);
      unpacked.index    = req_tdata[17:0];
      unpacked.symbol   = req_tdata[33:18];
      unpacked.target   = req_tdata[49:34];
      unpacked.score    = req_tdata[69:50];
      unpacked.limit    = req_tdata[88:70];
      unpacked.node     = req_tdata[104:89];
      unpacked.walk_sym = req_tdata[120:105];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_take;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= unpacked;
      end
   end
endmodule

@@ rtl/core/bnw_back.sv @@
// back part: node and arc memories, binary-search walk sequencer
// depends on bnw_pkg
module bnw_back #(
   parameter int unsigned NODE_COUNT = 65536,
   parameter int unsigned ARC_COUNT  = 262144,
   parameter int unsigned SCORE_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_take,
   input  bnw_pkg::item_type   q_item,
   input  logic [15:0]         final_node,
   input  logic [3:0]          max_hops,
   output logic                res_valid,
   input  logic                res_take,
   output bnw_pkg::result_type res_data
);
   import bnw_pkg::*;

   localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned AW = (ARC_COUNT > 1) ? $clog2(ARC_COUNT) : 1;
   localparam int unsigned LW = AW + 1;
   localparam int unsigned SW = 34;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LIM    = 9'b000000010,
      S_FIRST  = 9'b000000100,
      S_RANGE  = 9'b000001000,
      S_PROBE  = 9'b000010000,
      S_CMP    = 9'b000100000,
      S_HITRD  = 9'b001000000,
      S_MISS   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   logic [19:0] node_score_mem  [NODE_COUNT];
   logic [15:0] node_target_mem [NODE_COUNT];
   logic [18:0] node_limit_mem  [NODE_COUNT];
   logic [15:0] arc_symbol_mem  [ARC_COUNT];
   logic [15:0] arc_target_mem  [ARC_COUNT];
   logic [19:0] arc_score_mem   [ARC_COUNT];

   state_type   state_ff, state_in;
   logic [15:0] node_ff, node_in;
   logic [LW-1:0] lo_ff, lo_in, hi_ff, hi_in, lim_ff, lim_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [3:0]  hops_ff, hops_in;
   logic        res_valid_ff, res_valid_in;
   result_type  res_ff, res_in;
   logic [15:0] q_item_sym_ff;

   logic [NW-1:0] n_addr;
   logic [AW-1:0] a_addr;
   logic [19:0]   n_score_rd;
   logic [15:0]   n_target_rd;
   logic [18:0]   n_limit_rd;
   logic [15:0]   a_symbol_rd, a_target_rd;
   logic [19:0]   a_score_rd;
   logic          node_ok;
   logic [LW-1:0] clip_lim, mid;
   logic          n_wr, a_wr;
   logic [SW-1:0] sat_hi, sat_lo;

   function automatic logic [LW-1:0] clip(input logic [18:0] v);
      logic [LW+18:0] w;
      w = {{LW{1'b0}}, v};
      if (w > (LW+19)'(ARC_COUNT)) clip = LW'(ARC_COUNT);
      else clip = w[LW-1:0];
   endfunction

   assign node_ok = ({8'd0, node_ff} < 24'(NODE_COUNT)) || (NW > 16);
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign n_wr = (state_ff == S_IDLE) && q_valid && !res_valid_ff &&
                 (q_item.cmd == CMD_NODE_WR) && ({14'd0, q_item.index} < 32'(NODE_COUNT));
   assign a_wr = (state_ff == S_IDLE) && q_valid && !res_valid_ff &&
                 (q_item.cmd == CMD_ARC_WR) && ({14'd0, q_item.index} < 32'(ARC_COUNT));
   assign sat_hi = SW'((64'sd1 <<< (SCORE_BITS - 1)) - 1);
   assign sat_lo = SW'(-(64'sd1 <<< (SCORE_BITS - 1)));

   // node port address: node, or node-1 in S_FIRST, or index on a write
   always_comb begin
      if (state_ff == S_FIRST && n_limit_rd != '0 && node_ok) n_addr = NW'(node_ff - 16'd1);
      else if (state_ff == S_IDLE && n_wr) n_addr = NW'(q_item.index);
      else n_addr = NW'(node_ff);
      if (a_wr) a_addr = AW'(q_item.index);
      else if (state_ff == S_PROBE) a_addr = mid[AW-1:0];
      else a_addr = lo_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (n_wr) begin
         node_score_mem[n_addr]  <= q_item.score;
         node_target_mem[n_addr] <= q_item.target;
         node_limit_mem[n_addr]  <= q_item.limit;
      end
      n_score_rd  <= node_score_mem[n_addr];
      n_target_rd <= node_target_mem[n_addr];
      n_limit_rd  <= node_limit_mem[n_addr];
   end

   always_ff @(posedge clock) begin
      if (a_wr) begin
         arc_symbol_mem[a_addr] <= q_item.symbol;
         arc_target_mem[a_addr] <= q_item.target;
         arc_score_mem[a_addr]  <= q_item.score;
      end
      a_symbol_rd <= arc_symbol_mem[a_addr];
      a_target_rd <= arc_target_mem[a_addr];
      a_score_rd  <= arc_score_mem[a_addr];
   end

   assign clip_lim = clip(n_limit_rd);

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lim_in       = lim_ff;
      sum_in       = sum_ff;
      hops_in      = hops_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_take;
      q_take       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !res_valid_ff) begin
               q_take  = 1'b1;
               node_in = q_item.node;
               sum_in  = '0;
               hops_in = '0;
               res_in  = '0;
               if (q_item.cmd != CMD_WALK) begin
                  res_valid_in = 1'b1;
               end else if (q_item.node == final_node) begin
                  res_in.status = ST_START_FIN;
                  res_valid_in  = 1'b1;
               end else begin
                  state_in = S_LIM;
               end
            end
         end
         // node limit read in flight; next read node-1 limit
         S_LIM: begin
            state_in = S_FIRST;
         end
         S_FIRST: begin
            lim_in   = clip_lim;
            state_in = (n_limit_rd == '0 || !node_ok) ? S_MISS : S_RANGE;
         end
         S_RANGE: begin
            lo_in    = (node_ff == 16'd0) ? '0 : clip_lim;
            hi_in    = lim_ff;
            state_in = (((node_ff == 16'd0) ? '0 : clip_lim) >= lim_ff) ? S_MISS : S_PROBE;
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) state_in = S_CMP;
            else if (lo_ff < lim_ff) state_in = S_HITRD;
            else state_in = S_MISS;
            lim_in = lim_ff;
         end
         S_CMP: begin
            if (a_symbol_rd < q_item_sym_ff) lo_in = lo_ff + 1'b1 + ((hi_ff - lo_ff) >> 1);
            else hi_in = lo_ff + ((hi_ff - lo_ff) >> 1);
            state_in = S_PROBE;
         end
         S_HITRD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (a_symbol_rd == q_item_sym_ff) begin
               sum_in = sum_ff + SW'($signed(a_score_rd));
               res_in.next_node = a_target_rd;
               res_in.status = ST_OK;
               state_in = S_IDLE;
               res_valid_in = 1'b1;
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            // node port holds this node's entry on every path into here
            if (hops_ff >= max_hops) begin
               res_in.status = ST_HOP_LIMIT;
               res_in.next_node = '0;
               state_in = S_IDLE;
               res_valid_in = 1'b1;
            end else begin
               hops_in = hops_ff + 4'd1;
               if (node_ok) begin
                  sum_in  = sum_ff + SW'($signed(n_score_rd));
                  node_in = n_target_rd;
               end else begin
                  node_in = '0;
               end
               if ((node_ok ? n_target_rd : 16'd0) == final_node) begin
                  res_in.status = ST_REACH_FIN;
                  res_in.next_node = '0;
                  state_in = S_IDLE;
                  res_valid_in = 1'b1;
               end else begin
                  state_in = S_LIM;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_IDLE && state_in == S_IDLE) begin
         res_in.hops = hops_in;
         if ($signed(sum_in) > $signed(sat_hi)) begin
            res_in.score = sat_hi[19:0];
            res_in.sat   = 1'b1;
         end else if ($signed(sum_in) < $signed(sat_lo)) begin
            res_in.score = sat_lo[19:0];
            res_in.sat   = 1'b1;
         end else begin
            res_in.score = sum_in[19:0];
            res_in.sat   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) q_item_sym_ff <= q_item.walk_sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
      end
      node_ff <= node_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      lim_ff  <= lim_in;
      sum_ff  <= sum_in;
      hops_ff <= hops_in;
      res_ff  <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;
endmodule

@@ rtl/core/backoff_ngram_walk.sv @@
// top level of the backoff n-gram walk block
// depends on bnw_pkg, bnw_front and bnw_back
//
// usage:
//  - req_ channel carries one transaction per command: node write, arc write
//    or walk; writes load the node and arc tables, each entry written before use
//  - rsp_ channel returns exactly one result transaction per request, in order
//  - csr_ channel writes final_node (index 0) and max_hops (index 1); the user must
//    write them only while idle, the block does not enforce it
// sequencing:
//  - a write or a start-at-final walk finishes from the idle state; each node
//    visit reads the node limits (own, then node-1), runs the binary search
//    probes (arc read, then symbol compare), then closes the search with an arc
//    read and symbol check; a backoff then moves to the node's target; a search
//    over a full arc table makes up to 19 probes; the back part handles one item
//    at a time, the front queue holds two more
// reset: clears queue and sequencer, final_node to 0 and max_hops to 8;
//  table contents are undefined until written, no clearing pass; stall: a held
//  result blocks the sequencer, the queue keeps accepting until full, then req_tready drops
module backoff_ngram_walk #(
   parameter int unsigned NODE_COUNT = 65536,
   parameter int unsigned ARC_COUNT  = 262144,
   parameter int unsigned SCORE_BITS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command
   input  logic [bnw_pkg::REQ_USER_BITS-1:0] req_tuser,
   // entry_index, entry_symbol, entry_target, entry_score,
   // entry_limit, start_node, walk_symbol (low to high)
   input  logic [bnw_pkg::REQ_BYTES_BITS-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, score_saturated (low to high)
   output logic [bnw_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   // next_node, score_added, backoff_hops (low to high)
   output logic [bnw_pkg::RSP_BYTES_BITS-1:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import bnw_pkg::*;

   item_type    q_item;
   logic        q_valid, q_take;
   result_type  res;
   logic [15:0] final_node_ff;
   logic [3:0]  max_hops_ff;

   // config registers, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         final_node_ff <= '0;
         max_hops_ff   <= 4'd8;
      end else if (csr_valid) begin
         if (csr_index == 1'(CSR_FINAL_NODE)) final_node_ff <= csr_data;
         if (csr_index == 1'(CSR_MAX_HOPS))   max_hops_ff   <= csr_data[3:0];
      end
   end

   bnw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_take     (q_take),
      .q_item     (q_item)
   );

   bnw_back #(
      .NODE_COUNT (NODE_COUNT),
      .ARC_COUNT  (ARC_COUNT),
      .SCORE_BITS (SCORE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_take     (q_take),
      .q_item     (q_item),
      .final_node (final_node_ff),
      .max_hops   (max_hops_ff),
      .res_valid  (rsp_tvalid),
      .res_take   (rsp_tready),
      .res_data   (res)
   );

   // pack result fields, lowest first
   assign rsp_tuser = {res.sat, res.status};
   assign rsp_tdata = {res.hops, res.score, res.next_node};

   // a result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");
   // start at final node gives zero hops and no next node
   a_start_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.status == ST_START_FIN |-> res.hops == 4'd0 && res.next_node == 16'd0)
      else $error("bad start-final result");
   // errors never carry a node
   a_err_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (res.status == ST_REACH_FIN || res.status == ST_HOP_LIMIT)
      |-> res.next_node == 16'd0)
      else $error("error result with node");
endmodule
